// ===== hdl/ecq_pkg.sv =====
// Package with the item types, state codes and constants of the M/M/c queue block.
package ecq_pkg;

  localparam int MAX_SERVERS_DEF = 64;
  localparam int FRAC_BITS_DEF   = 16;

  // Status codes of a result item.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_SATURATED  = 2'd1;
  localparam logic [1:0] STATUS_NO_SERVICE = 2'd2;

  typedef struct packed {
    logic [31:0] arrival_rate;
    logic [31:0] service_rate;
    logic [6:0]  server_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] utilization;
    logic [31:0] empty_probability;
    logic [47:0] mean_queue_length;
    logic [47:0] mean_wait;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_D,
    ST_UTIL,
    ST_R,
    ST_LMUL,
    ST_LDIV,
    ST_LNORM,
    ST_TM,
    ST_TD,
    ST_TNORM,
    ST_P0,
    ST_A,
    ST_LQM,
    ST_LQD,
    ST_LQM2,
    ST_LQD2,
    ST_WM,
    ST_WD,
    ST_WD2,
    ST_OUT
  } state_e;

endpackage

// ===== hdl/erlang_c_queue_metrics.sv =====
// Top level: M/M/c queue figures computed by a sequencer over a shared multiplier and divider.
// Each product and each short or long division runs on the shared units in turn, and terms are
// halved one step at a time while renormalized. One item is in work at a time: the block takes
// no new item until the result is taken. Saturated items and a zero service rate finish early.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle.
module erlang_c_queue_metrics
  import ecq_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int K  = 2 * FRAC_BITS - 40;
  localparam int KL = (K >= 0) ? K : 0;
  localparam int KR = (K < 0) ? -K : 0;
  localparam int LQ_SHIFT = 40 - FRAC_BITS;

  state_e state_q, state_d;

  logic [31:0]  lam_q, mu_q;
  logic [6:0]   c_q, n_q;
  logic [63:0]  d_q, g_q, r_q, t_q, s_q, p_q, a_q;
  logic [15:0]  e_q;
  logic [127:0] tot_q, v_q;
  logic [31:0]  util_q, p0_q;
  logic [47:0]  lq_q, wq_q;
  logic [1:0]   status_q;
  logic         started_q;

  logic         mul_op, div_op, div_long;
  logic         mul_start, div_start, mul_done, div_done, op_done;
  logic [127:0] mul_a, mul_p, div_x, div_q;
  logic [63:0]  mul_b, div_y;
  logic [6:0]   c_in;

  function automatic logic [47:0] sat48(input logic [127:0] x);
    sat48 = (|x[127:48]) ? '1 : x[47:0];
  endfunction

  ecq_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  ecq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .long_i     (div_long),
    .dividend_i (div_x),
    .divisor_i  (div_y),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign op_done = mul_done || div_done;

  // Server count clamped to 1..MAX_SERVERS.
  always_comb begin
    c_in = in_data_i.server_count;
    if (c_in == 7'd0) begin
      c_in = 7'd1;
    end else if (int'(c_in) > MAX_SERVERS) begin
      c_in = 7'(MAX_SERVERS);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_D;
      ST_D:     if (op_done) state_d = (mu_q == 32'd0) ? ST_OUT : ST_UTIL;
      ST_UTIL:  if (op_done) state_d = (64'(lam_q) >= d_q) ? ST_OUT : ST_R;
      ST_R:     if (op_done) state_d = ST_LMUL;
      ST_LMUL:  if (op_done) state_d = ST_LDIV;
      ST_LDIV:  if (op_done) state_d = ST_LNORM;
      ST_LNORM: begin
        if (t_q[63:31] == '0) state_d = (n_q == c_q) ? ST_TM : ST_LMUL;
      end
      ST_TM:    if (op_done) state_d = ST_TD;
      ST_TD:    if (op_done) state_d = ST_TNORM;
      ST_TNORM: if (tot_q[127:62] == '0) state_d = ST_P0;
      ST_P0: begin
        if (tot_q == '0) state_d = ST_LQM;
        else if (op_done) state_d = ST_A;
      end
      ST_A:     if (op_done) state_d = ST_LQM;
      ST_LQM:   if (op_done) state_d = ST_LQD;
      ST_LQD:   if (op_done) state_d = ST_LQM2;
      ST_LQM2:  if (op_done) state_d = ST_LQD2;
      ST_LQD2:  if (op_done) state_d = ST_WM;
      ST_WM:    if (op_done) state_d = ST_WD;
      ST_WD:    if (op_done) state_d = ST_WD2;
      ST_WD2:   if (op_done) state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Unit requests and operands for each state.
  always_comb begin
    mul_op   = 1'b0;
    div_op   = 1'b0;
    div_long = 1'b1;
    mul_a    = '0;
    mul_b    = '0;
    div_x    = '0;
    div_y    = g_q;
    case (state_q)
      ST_D: begin
        mul_op = 1'b1; mul_a = 128'(mu_q); mul_b = 64'(c_q);
      end
      ST_UTIL: begin
        div_op = 1'b1; div_long = 1'b0;
        div_x = {64'b0, 64'(lam_q) << FRAC_BITS}; div_y = d_q;
      end
      ST_R: begin
        div_op = 1'b1; div_long = 1'b0;
        div_x = {64'b0, 64'(lam_q) << 24}; div_y = 64'(mu_q);
      end
      ST_LMUL: begin
        mul_op = 1'b1; mul_a = 128'(t_q); mul_b = r_q;
      end
      ST_LDIV: begin
        div_op = 1'b1; div_long = 1'b0;
        div_x = {64'b0, p_q}; div_y = 64'(n_q) + 64'd1;
      end
      ST_TM: begin
        mul_op = 1'b1; mul_a = 128'(t_q); mul_b = d_q;
      end
      ST_TD: begin
        div_op = 1'b1; div_x = v_q;
      end
      ST_P0: begin
        div_op = (tot_q != '0); div_long = 1'b0;
        div_x = (e_q > 16'd55) ? '0 : {64'b0, 64'd1 << 6'(16'd55 - e_q)};
        div_y = tot_q[63:0];
      end
      ST_A: begin
        div_op = 1'b1; div_x = 128'(t_q) << 40; div_y = tot_q[63:0];
      end
      ST_LQM: begin
        mul_op = 1'b1; mul_a = 128'(a_q); mul_b = 64'(lam_q);
      end
      ST_LQD, ST_LQD2, ST_WD: begin
        div_op = 1'b1; div_x = v_q;
      end
      ST_LQM2: begin
        mul_op = 1'b1; mul_a = v_q; mul_b = d_q;
      end
      ST_WM: begin
        mul_op = 1'b1; mul_a = 128'(a_q); mul_b = d_q;
      end
      ST_WD2: begin
        div_op = 1'b1; div_x = v_q << KL;
      end
      default: begin
        mul_op = 1'b0;
      end
    endcase
    mul_start = mul_op && !started_q;
    div_start = div_op && !started_q;
  end

  // Handshake outputs and the result item.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    out_data_o.utilization       = util_q;
    out_data_o.empty_probability = p0_q;
    out_data_o.mean_queue_length = lq_q;
    out_data_o.mean_wait         = wq_q;
    out_data_o.status            = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      started_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (op_done) begin
        started_q <= 1'b0;
      end else if (mul_start || div_start) begin
        started_q <= 1'b1;
      end
    end
  end

  // Datapath registers, written on input acceptance, as each operation finishes and while renormalizing.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          lam_q <= in_data_i.arrival_rate;
          mu_q  <= in_data_i.service_rate;
          c_q   <= c_in;
        end
      end
      ST_D: begin
        if (op_done) begin
          d_q <= mul_p[63:0];
          if (mu_q == 32'd0) begin
            util_q   <= '1;
            p0_q     <= '0;
            lq_q     <= '1;
            wq_q     <= '1;
            status_q <= STATUS_NO_SERVICE;
          end
        end
      end
      ST_UTIL: begin
        if (op_done) begin
          util_q <= (|div_q[127:32]) ? '1 : div_q[31:0];
          g_q    <= d_q - 64'(lam_q);
          if (64'(lam_q) >= d_q) begin
            p0_q     <= '0;
            lq_q     <= '1;
            wq_q     <= '1;
            status_q <= STATUS_SATURATED;
          end
        end
      end
      ST_R: begin
        if (op_done) begin
          r_q <= div_q[63:0];
          t_q <= 64'd1 << 24;
          s_q <= '0;
          e_q <= '0;
          n_q <= '0;
        end
      end
      ST_LMUL: begin
        if (op_done) begin
          s_q <= s_q + t_q;
          p_q <= mul_p[87:24];
        end
      end
      ST_LDIV: begin
        if (op_done) begin
          t_q <= div_q[63:0];
          n_q <= n_q + 7'd1;
        end
      end
      ST_LNORM: begin
        if (t_q[63:31] != '0) begin
          t_q <= t_q >> 1;
          s_q <= s_q >> 1;
          e_q <= e_q + 16'd1;
        end
      end
      ST_TM, ST_LQM, ST_LQM2, ST_WM: begin
        if (op_done) v_q <= mul_p;
      end
      ST_TD: begin
        if (op_done) tot_q <= div_q + 128'(s_q);
      end
      ST_TNORM: begin
        if (tot_q[127:62] != '0) begin
          tot_q <= tot_q >> 1;
          t_q   <= t_q >> 1;
          e_q   <= e_q + 16'd1;
        end
      end
      ST_P0: begin
        if (tot_q == '0) begin
          p0_q <= 32'h8000_0000;
          a_q  <= '0;
        end else if (op_done) begin
          p0_q <= (div_q > 128'h8000_0000) ? 32'h8000_0000 : div_q[31:0];
        end
      end
      ST_A: begin
        if (op_done) a_q <= div_q[63:0];
      end
      ST_LQD, ST_WD: begin
        if (op_done) v_q <= div_q;
      end
      ST_LQD2: begin
        if (op_done) lq_q <= sat48(div_q >> LQ_SHIFT);
      end
      ST_WD2: begin
        if (op_done) begin
          wq_q     <= sat48(div_q >> KR);
          status_q <= STATUS_OK;
        end
      end
      default: begin
        status_q <= status_q;
      end
    endcase
  end

endmodule

// ===== hdl/ecq_mul.sv =====
// Shared multiplier: 128 by 64 bit product modulo 2^128 from 32 by 32 bit partial products.
module ecq_mul
  import ecq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic [127:0] a_q;
  logic [63:0]  b_q;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  pp_q;
  logic [2:0]   sh_q;
  logic         pp_vld_q;
  logic         pp_last_q;
  logic [2:0]   idx_q;
  logic         busy_q;
  logic         done_q;
  logic [31:0]  a_limb;
  logic [31:0]  b_limb;
  logic [2:0]   sh_d;

  // Select the limbs of the current step: a limb in the upper index bits, b limb in the lowest.
  always_comb begin
    a_limb = a_q[{idx_q[2:1], 5'b0} +: 32];
    b_limb = b_q[{idx_q[0], 5'b0} +: 32];
    sh_d   = {1'b0, idx_q[2:1]} + {2'b0, idx_q[0]};
  end

  // Add the registered partial product at its limb offset; offsets past 128 bits drop out.
  always_comb begin
    acc_d = acc_q;
    if (pp_vld_q && (sh_q < 3'd4)) begin
      acc_d = acc_q + (128'(pp_q) << {sh_q[1:0], 5'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pp_vld_q  <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
      idx_q     <= '0;
    end else begin
      done_q   <= pp_vld_q && pp_last_q;
      pp_vld_q <= busy_q;
      pp_last_q <= busy_q && (idx_q == 3'd7);
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand latch, product register and accumulator.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
    pp_q <= 64'(a_limb) * 64'(b_limb);
    sh_q <= sh_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hdl/ecq_div.sv =====
// Shared restoring divider: 128 or 64 bit dividend by 64 bit divisor, one quotient bit a cycle.
module ecq_div
  import ecq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         long_i,
  input  logic [127:0] dividend_i,
  input  logic [63:0]  divisor_i,
  output logic         done_o,
  output logic [127:0] quot_o
);

  logic [127:0] x_q;
  logic [127:0] q_q;
  logic [63:0]  rem_q;
  logic [63:0]  dv_q;
  logic [7:0]   cnt_q;
  logic         busy_q;
  logic         done_q;
  logic [64:0]  trial;
  logic         take;

  // Shift in the next dividend bit; the bit shifted out of the remainder forces a subtract.
  always_comb begin
    trial = {rem_q, x_q[127]};
    take  = trial[64] || (trial[63:0] >= dv_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= long_i ? 8'd128 : 8'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 8'd1;
        if (cnt_q == 8'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Working registers; a short division starts at bit 63 of the dividend.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= long_i ? dividend_i : {dividend_i[63:0], 64'b0};
      q_q   <= '0;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      x_q   <= {x_q[126:0], 1'b0};
      q_q   <= {q_q[126:0], take};
      rem_q <= take ? (trial[63:0] - dv_q) : trial[63:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// ===== hdl/ecq_checker.sv =====
// Port-level assertions for the queue figures block, bound to the top level.
module ecq_checker
  import ecq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // A waiting result item holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  // The block never takes an item while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a result is pending");

  // An accepted item keeps the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // A zero service rate gives full utilization and an empty probability of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_NO_SERVICE) |->
      (out_data_o.utilization == '1) && (out_data_o.empty_probability == '0))
    else $error("bad figures for a zero service rate");

  // Any status other than OK reports all-ones length and wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_OK) |->
      (out_data_o.mean_queue_length == '1) && (out_data_o.mean_wait == '1))
    else $error("length or wait not saturated");

endmodule

bind erlang_c_queue_metrics ecq_checker u_ecq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the M/M/c queue figures block.
module tb_top;
  import ecq_pkg::*;

  localparam int NUM_RANDOM = 950;
  localparam int QMAX       = MAX_SERVERS_DEF;
  localparam int FB         = FRAC_BITS_DEF;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  in_item_t  pending_items[$];
  out_item_t expected_figures[$];
  int        mismatch_count = 0;
  bit        stimulus_done = 1'b0;
  bit        in_accepted = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_phase = 0;

  erlang_c_queue_metrics dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Saturate a wide value to 48 bits.
  function automatic logic [47:0] sat48(input logic [255:0] x);
    if (x > 256'hFFFF_FFFF_FFFF) return '1;
    return x[47:0];
  endfunction

  // Compute the expected queue figures for one query.
  function automatic out_item_t queue_figures(input in_item_t q);
    out_item_t res;
    logic [255:0] lam, mu, c, d, g, r, t, s, tot, p0, a, v, util;
    int unsigned e;
    lam = q.arrival_rate;
    mu  = q.service_rate;
    c   = q.server_count;
    e   = 0;
    if (c == 0) c = 1;
    if (c > QMAX) c = QMAX;
    d = mu * c;
    if (mu == 0) begin
      res.utilization = '1; res.empty_probability = '0;
      res.mean_queue_length = '1; res.mean_wait = '1; res.status = STATUS_NO_SERVICE;
      return res;
    end
    util = (lam << FB) / d;
    if (util > 256'hFFFF_FFFF) util = 256'hFFFF_FFFF;
    res.utilization = util[31:0];
    if (lam >= d) begin
      res.empty_probability = '0;
      res.mean_queue_length = '1; res.mean_wait = '1; res.status = STATUS_SATURATED;
      return res;
    end
    g = d - lam;
    r = (lam << 24) / mu;
    t = 256'd1 << 24;
    s = 0;
    for (int n = 0; n < c; n++) begin
      s = s + t;
      t = (t * r) / ((n + 1) << 24);
      while (t >= (256'd1 << 31)) begin
        t = t >> 1; s = s >> 1; e++;
      end
    end
    tot = (t * d) / g + s;
    while (tot >= (256'd1 << 62)) begin
      tot = tot >> 1; t = t >> 1; e++;
    end
    if (tot == 0) begin
      p0 = 256'd1 << 31;
      a = 0;
    end else begin
      p0 = (e > 55) ? 256'd0 : ((256'd1 << (55 - e)) / tot);
      if (p0 > (256'd1 << 31)) p0 = 256'd1 << 31;
      a = ((t << 40) / tot) & 256'hFFFF_FFFF_FFFF_FFFF;
    end
    res.empty_probability = p0[31:0];
    v = (((a * lam) / g) * d) / g;
    res.mean_queue_length = sat48(v >> (40 - FB));
    v = (a * d) / g;
    if (2 * FB - 40 >= 0) v = (v << (2 * FB - 40)) / g;
    else v = (v / g) >> (40 - 2 * FB);
    res.mean_wait = sat48(v);
    res.status = STATUS_OK;
    return res;
  endfunction

  function automatic in_item_t make_query(input logic [31:0] l, input logic [31:0] m,
                                          input logic [6:0] c);
    in_item_t q;
    q.arrival_rate = l; q.service_rate = m; q.server_count = c;
    return q;
  endfunction

  // Fill the queue of pending queries: directed corners, then random.
  initial begin
    logic [31:0] m, l;
    logic [6:0]  c;
    pending_items.push_back(make_query(32'h0001_0000, 32'h0, 7'd1));
    pending_items.push_back(make_query(32'hFFFF_FFFF, 32'h0, 7'd127));
    pending_items.push_back(make_query(32'h0, 32'h0001_0000, 7'd1));
    pending_items.push_back(make_query(32'h0, 32'hFFFF_FFFF, 7'd64));
    pending_items.push_back(make_query(32'h0002_0000, 32'h0001_0000, 7'd1));
    pending_items.push_back(make_query(32'h0001_0000, 32'h0001_0000, 7'd1));
    pending_items.push_back(make_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd2));
    pending_items.push_back(make_query(32'hFFFF_FFFE, 32'hFFFF_FFFF, 7'd1));
    pending_items.push_back(make_query(32'h0000_8000, 32'h0001_0000, 7'd0));
    pending_items.push_back(make_query(32'h0030_0000, 32'h0001_0000, 7'd127));
    pending_items.push_back(make_query(32'h003F_0000, 32'h0001_0000, 7'd64));
    pending_items.push_back(make_query(32'hFFFF_FFFF, 32'h0400_0000, 7'd64));
    pending_items.push_back(make_query(32'h0000_0001, 32'h0000_0001, 7'd2));
    pending_items.push_back(make_query(32'h0000_0001, 32'hFFFF_FFFF, 7'd1));
    pending_items.push_back(make_query(32'h0001_0000, 32'h0000_0001, 7'd64));
    pending_items.push_back(make_query(32'h0013_0000, 32'h0001_0000, 7'd20));
    pending_items.push_back(make_query(32'h7FFF_FFFF, 32'h8000_0000, 7'd1));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      c = (($urandom_range(0, 9)) == 0) ? 7'($urandom) : 7'($urandom_range(1, 12));
      m = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0010_0000);
      if ($urandom_range(0, 49) == 0) m = 0;
      case ($urandom_range(0, 5))
        0: l = $urandom;
        1: l = 0;
        default: begin
          // Mostly stable systems with rho spread over [0,1).
          l = 32'((64'(m) * ((c == 0) ? 1 : (c > 64 ? 64 : c)) *
                   $urandom_range(0, 1023)) >> 10);
        end
      endcase
      pending_items.push_back(make_query(l, m, c));
    end
  end

  // Reset, then wait for the run to drain.
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stimulus_done && expected_figures.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1_000_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Flag an input item taken at this rising edge for the driver.
  always @(posedge clk_i) begin
    in_accepted <= rst_ni && in_valid_i && in_ready_o;
  end

  // Driver: bursts of items with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_accepted)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 6);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // Receiver stall pattern: long ready windows alternating with stalls.
  always @(negedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 97;
    out_ready_i <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_figures.push_back(queue_figures(in_data_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_figures.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = expected_figures.pop_front();
        if (want !== out_data_o) begin
          $display("%0t: mismatch expected util=%h p0=%h lq=%h wq=%h st=%0d", $time,
                   want.utilization, want.empty_probability, want.mean_queue_length,
                   want.mean_wait, want.status);
          $display("%0t:          actual   util=%h p0=%h lq=%h wq=%h st=%0d", $time,
                   out_data_o.utilization, out_data_o.empty_probability,
                   out_data_o.mean_queue_length, out_data_o.mean_wait, out_data_o.status);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

endmodule

// ===== sim.f =====
hdl/ecq_pkg.sv
hdl/ecq_mul.sv
hdl/ecq_div.sv
hdl/erlang_c_queue_metrics.sv
hdl/ecq_checker.sv
tb/tb_top.sv
